### design/layer_compositor_resolver_unit_defines.svh
// Assertion macros shared by the layer compositor RTL
`ifndef LAYER_COMPOSITOR_RESOLVER_UNIT_DEFINES_SVH
`define LAYER_COMPOSITOR_RESOLVER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LCR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define LCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/lcr_pkg.sv
// Package: types, constants and codes of the layer compositor resolver
package lcr_pkg;

   localparam int MAX_LAYERS = 16;
   localparam int LCR_ADDR_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LCR_CNT_W  = $clog2(MAX_LAYERS + 1);

   localparam logic [2:0] CMD_CREATE  = 3'd0;
   localparam logic [2:0] CMD_MOVE    = 3'd1;
   localparam logic [2:0] CMD_REFRESH = 3'd2;
   localparam logic [2:0] CMD_RESOLVE = 3'd3;
   localparam logic [2:0] CMD_FLUSH   = 3'd4;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [10:0] SCREEN_WIDTH_RESET  = 11'd320;
   localparam logic [10:0] SCREEN_HEIGHT_RESET = 11'd200;

   typedef struct packed {
      logic [2:0]         command;
      logic [3:0]         layer_index;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [10:0]        size_w;
      logic [10:0]        size_h;
   } req_type;

   typedef struct packed {
      logic        status;
      logic        hit;
      logic [3:0]  found_layer;
      logic [21:0] buffer_offset;
      logic [10:0] rect_x0;
      logic [10:0] rect_x1;
      logic [10:0] rect_y0;
      logic [10:0] rect_y1;
   } rsp_type;

   typedef struct packed {
      logic signed [11:0] left;
      logic signed [11:0] top;
      logic [10:0]        wide;
      logic [10:0]        tall;
   } layer_entry_type;

   typedef struct packed {
      logic signed [11:0] left;
      logic signed [11:0] top;
      logic [12:0]        wide;
      logic [12:0]        tall;
   } dirty_type;

endpackage

### design/lcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module lcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/layer_compositor_resolver_unit.sv
// Top level: layer table sequencer, dirty rectangle and pixel resolve
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_stall | req_type
//  rsp_    | out       | rsp_valid/rsp_stall | rsp_type
//  csr_    | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One transaction at a time. Create, flush and errors go from idle to the done state, then to the output register.
// Move and refresh: one table read, one merge per rectangle (move merges the old and new, refresh the old).
// Resolve scans the layers top down, one table read per cycle, and on a hit adds
// a multiply state for the offset.
// Synchronous reset empties the table and dirty rectangle; no clearing pass.
// A stalled result sits in the output register while the next transaction runs.
`include "layer_compositor_resolver_unit_defines.svh"

module layer_compositor_resolver_unit
   import lcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [10:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MERGE, ST_MERGE2, ST_SCAN, ST_MUL, ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [LCR_CNT_W-1:0]   count_ff, count_in;
   logic [LCR_ADDR_W-1:0]  ptr_ff, ptr_in;
   dirty_type              dirty_ff, dirty_in;
   logic [10:0]            scr_w_ff, scr_w_in;
   logic [10:0]            scr_h_ff, scr_h_in;
   layer_entry_type        ent_ff, ent_in;
   logic [10:0]            lx_ff, lx_in;
   logic [10:0]            ly_ff, ly_in;
   rsp_type                res_ff, res_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic                   wr_en, rd_en;
   logic [LCR_ADDR_W-1:0]  wr_addr, rd_addr;
   layer_entry_type        wr_data, rd_data;
   logic [LCR_CNT_W-1:0]   count_m1;
   logic signed [13:0]     dx, dy, dirty_x1, dirty_y1;
   logic                   covered;
   logic [21:0]            product;

   function automatic logic signed [13:0] sext12(input logic signed [11:0] v);
      return $signed({{2{v[11]}}, v});
   endfunction

   function automatic dirty_type merge_rect(input dirty_type d,
                                            input logic signed [11:0] x,
                                            input logic signed [11:0] y,
                                            input logic [10:0] w,
                                            input logic [10:0] h);
      dirty_type r;
      logic signed [13:0] dx1, nx1, dy1, ny1, x0, x1, y0, y1;
      dx1 = sext12(d.left) + $signed({1'b0, d.wide});
      nx1 = sext12(x) + $signed({3'b000, w});
      dy1 = sext12(d.top) + $signed({1'b0, d.tall});
      ny1 = sext12(y) + $signed({3'b000, h});
      x0  = (sext12(d.left) < sext12(x)) ? sext12(d.left) : sext12(x);
      y0  = (sext12(d.top) < sext12(y)) ? sext12(d.top) : sext12(y);
      x1  = (dx1 > nx1) ? dx1 : nx1;
      y1  = (dy1 > ny1) ? dy1 : ny1;
      if (d.wide == '0 && d.tall == '0) begin
         r.left = x;
         r.top  = y;
         r.wide = {2'b00, w};
         r.tall = {2'b00, h};
      end else begin
         r.left = x0[11:0];
         r.top  = y0[11:0];
         r.wide = 13'(x1 - x0);
         r.tall = 13'(y1 - y0);
      end
      return r;
   endfunction

   function automatic logic [10:0] clamp_screen(input logic signed [13:0] v,
                                                input logic [10:0] lim);
      logic [10:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed({3'b000, lim})) begin
         r = lim;
      end else begin
         r = v[10:0];
      end
      return r;
   endfunction

   lcr_ram #(
      .WIDTH ($bits(layer_entry_type)),
      .DEPTH (MAX_LAYERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign count_m1 = count_ff - 1'b1;
   assign dx       = sext12(req_ff.pos_x) - sext12(rd_data.left);
   assign dy       = sext12(req_ff.pos_y) - sext12(rd_data.top);
   assign covered  = (dx >= 0) && (dx < $signed({3'b000, rd_data.wide})) &&
                     (dy >= 0) && (dy < $signed({3'b000, rd_data.tall}));
   assign dirty_x1 = sext12(dirty_ff.left) + $signed({1'b0, dirty_ff.wide});
   assign dirty_y1 = sext12(dirty_ff.top) + $signed({1'b0, dirty_ff.tall});
   assign product  = ly_ff * ent_ff.wide;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      dirty_in     = dirty_ff;
      scr_w_in     = scr_w_ff;
      scr_h_in     = scr_h_ff;
      ent_in       = ent_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = ent_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  scr_w_in = csr_data;
            CSR_SCREEN_HEIGHT: scr_h_in = csr_data;
            default:           ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               res_in   = '0;
               state_in = ST_DONE;
               unique case (req_payload.command)
                  CMD_CREATE: begin
                     if (count_ff == LCR_CNT_W'(MAX_LAYERS)) begin
                        res_in.status = 1'b1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = count_ff[LCR_ADDR_W-1:0];
                        wr_data = '{left: req_payload.pos_x, top: req_payload.pos_y,
                                    wide: req_payload.size_w, tall: req_payload.size_h};
                        res_in.found_layer = 4'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_MOVE, CMD_REFRESH: begin
                     if (32'(req_payload.layer_index) >= 32'(count_ff)) begin
                        res_in.status = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = LCR_ADDR_W'(req_payload.layer_index);
                        state_in = ST_MERGE;
                     end
                  end
                  CMD_RESOLVE: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = count_m1[LCR_ADDR_W-1:0];
                        ptr_in   = count_m1[LCR_ADDR_W-1:0];
                        state_in = ST_SCAN;
                     end
                  end
                  CMD_FLUSH: begin
                     res_in.rect_x0 = clamp_screen(sext12(dirty_ff.left), scr_w_ff);
                     res_in.rect_x1 = clamp_screen(dirty_x1, scr_w_ff);
                     res_in.rect_y0 = clamp_screen(sext12(dirty_ff.top), scr_h_ff);
                     res_in.rect_y1 = clamp_screen(dirty_y1, scr_h_ff);
                     dirty_in       = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            ent_in   = rd_data;
            dirty_in = merge_rect(dirty_ff, rd_data.left, rd_data.top,
                                  rd_data.wide, rd_data.tall);
            if (req_ff.command == CMD_MOVE) begin
               wr_en    = 1'b1;
               wr_addr  = LCR_ADDR_W'(req_ff.layer_index);
               wr_data  = '{left: req_ff.pos_x, top: req_ff.pos_y,
                            wide: rd_data.wide, tall: rd_data.tall};
               state_in = ST_MERGE2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MERGE2: begin
            dirty_in = merge_rect(dirty_ff, req_ff.pos_x, req_ff.pos_y,
                                  ent_ff.wide, ent_ff.tall);
            state_in = ST_DONE;
         end
         ST_SCAN: begin
            if (covered) begin
               ent_in             = rd_data;
               lx_in              = dx[10:0];
               ly_in              = dy[10:0];
               res_in.hit         = 1'b1;
               res_in.found_layer = 4'(ptr_ff);
               state_in           = ST_MUL;
            end else if (ptr_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff - 1'b1;
               ptr_in  = ptr_ff - 1'b1;
            end
         end
         ST_MUL: begin
            res_in.buffer_offset = product + {11'd0, lx_ff};
            state_in             = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dirty_ff     <= '0;
         scr_w_ff     <= SCREEN_WIDTH_RESET;
         scr_h_ff     <= SCREEN_HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dirty_ff     <= dirty_in;
         scr_w_ff     <= scr_w_in;
         scr_h_ff     <= scr_h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      ptr_ff <= ptr_in;
      ent_ff <= ent_in;
      lx_ff  <= lx_in;
      ly_ff  <= ly_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   `LCR_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= LCR_CNT_W'(MAX_LAYERS),
      "layer count above table depth")
   `LCR_ASSERT_NOW(a_scan_ptr, state_ff == ST_SCAN, 32'(ptr_ff) < 32'(count_ff),
      "scan pointer outside created layers")
   `LCR_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, state_ff != ST_IDLE,
      "sequencer idle right after a transaction was taken")
   `LCR_ASSERT_NEXT(a_flush_clears,
      req_valid && !req_stall && req_payload.command == CMD_FLUSH,
      dirty_ff.wide == '0 && dirty_ff.tall == '0,
      "dirty rectangle not empty after flush")

endmodule

### test/tb_layer_compositor_resolver_unit.sv
// Testbench for the layer compositor resolver: directed rows, random traffic, result checks
`timescale 1ns / 1ps

module tb_layer_compositor_resolver_unit;
   import lcr_pkg::*;

   localparam int HALF_HI = 6;
   localparam int HALF_LO = 6;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_SCREEN_WIDTH;
   logic [10:0] csr_data = '0;

   layer_compositor_resolver_unit dut (.*);

   always begin
      #HALF_HI clock = 1'b0;
      #HALF_LO clock = 1'b1;
   end

   // shadow copy of the block state
   int lay_left[MAX_LAYERS];
   int lay_top[MAX_LAYERS];
   int lay_wide[MAX_LAYERS];
   int lay_tall[MAX_LAYERS];
   int lay_count;
   int dirty_x, dirty_y, dirty_w, dirty_h;
   int scr_w, scr_h;

   rsp_type pending_rsp[$];
   int      errors = 0;
   bit      no_idle = 1'b0;
   int      quiet_cycles = 0;

   function automatic void merge_dirty(int x, int y, int w, int h);
      int x0, x1, y0, y1;
      if (dirty_w == 0 && dirty_h == 0) begin
         dirty_x = x; dirty_y = y; dirty_w = w; dirty_h = h;
      end else begin
         x0 = (dirty_x < x) ? dirty_x : x;
         x1 = (dirty_x + dirty_w > x + w) ? dirty_x + dirty_w : x + w;
         y0 = (dirty_y < y) ? dirty_y : y;
         y1 = (dirty_y + dirty_h > y + h) ? dirty_y + dirty_h : y + h;
         dirty_x = x0; dirty_y = y0; dirty_w = x1 - x0; dirty_h = y1 - y0;
      end
   endfunction

   function automatic logic [10:0] clamp_screen(int v, int lim);
      if (v < 0) return '0;
      if (v > lim) return 11'(lim);
      return 11'(v);
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      int      px, py, k, i;
      o = '0;
      px = r.pos_x;
      py = r.pos_y;
      i = r.layer_index;
      case (r.command)
         CMD_CREATE: begin
            if (lay_count >= MAX_LAYERS) begin
               o.status = 1'b1;
            end else begin
               lay_left[lay_count] = px;
               lay_top[lay_count]  = py;
               lay_wide[lay_count] = r.size_w;
               lay_tall[lay_count] = r.size_h;
               o.found_layer = 4'(lay_count);
               lay_count++;
            end
         end
         CMD_MOVE, CMD_REFRESH: begin
            if (i >= lay_count) begin
               o.status = 1'b1;
            end else begin
               merge_dirty(lay_left[i], lay_top[i], lay_wide[i], lay_tall[i]);
               if (r.command == CMD_MOVE) begin
                  lay_left[i] = px;
                  lay_top[i]  = py;
                  merge_dirty(lay_left[i], lay_top[i], lay_wide[i], lay_tall[i]);
               end
            end
         end
         CMD_RESOLVE: begin
            for (k = lay_count - 1; k >= 0; k--) begin
               if (lay_left[k] <= px && px < lay_left[k] + lay_wide[k] &&
                   lay_top[k] <= py && py < lay_top[k] + lay_tall[k]) begin
                  o.hit = 1'b1;
                  o.found_layer = 4'(k);
                  o.buffer_offset = 22'((py - lay_top[k]) * lay_wide[k] + (px - lay_left[k]));
                  break;
               end
            end
         end
         CMD_FLUSH: begin
            o.rect_x0 = clamp_screen(dirty_x, scr_w);
            o.rect_x1 = clamp_screen(dirty_x + dirty_w, scr_w);
            o.rect_y0 = clamp_screen(dirty_y, scr_h);
            o.rect_y1 = clamp_screen(dirty_y + dirty_h, scr_h);
            dirty_x = 0; dirty_y = 0; dirty_w = 0; dirty_h = 0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // drive one transaction; typed rows override the predicted result
   task automatic send_req(req_type r, bit typed, rsp_type typed_rsp);
      rsp_type p;
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = predict_rsp(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [10:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SCREEN_WIDTH) scr_w = val;
      else scr_h = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type mk_req(logic [2:0] c, int idx, int x, int y, int w, int h);
      req_type r;
      r.command = c;
      r.layer_index = 4'(idx);
      r.pos_x = 12'(x);
      r.pos_y = 12'(y);
      r.size_w = 11'(w);
      r.size_h = 11'(h);
      return r;
   endfunction

   function automatic rsp_type mk_rsp(bit st, bit h, int lay, int off);
      rsp_type o;
      o = '0;
      o.status = st;
      o.hit = h;
      o.found_layer = 4'(lay);
      o.buffer_offset = 22'(off);
      return o;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      sel, t;
      r = req_type'({$urandom, $urandom});
      sel = $urandom_range(0, 99);
      if (sel < 15) r.command = CMD_CREATE;
      else if (sel < 35) r.command = CMD_MOVE;
      else if (sel < 50) r.command = CMD_REFRESH;
      else if (sel < 85) r.command = CMD_RESOLVE;
      else if (sel < 95) r.command = CMD_FLUSH;
      else r.command = 3'($urandom_range(5, 7));
      if (lay_count > 0 && $urandom_range(0, 99) < 85)
         r.layer_index = 4'($urandom_range(0, lay_count - 1));
      if ($urandom_range(0, 99) < 80) begin
         r.pos_x  = 12'(int'($urandom_range(0, 500)) - 100);
         r.pos_y  = 12'(int'($urandom_range(0, 500)) - 100);
         r.size_w = 11'($urandom_range(0, 300));
         r.size_h = 11'($urandom_range(0, 300));
      end
      // aim most resolves inside an existing layer
      if (r.command == CMD_RESOLVE && lay_count > 0 && $urandom_range(0, 99) < 70) begin
         t = $urandom_range(0, lay_count - 1);
         if (lay_wide[t] > 0 && lay_tall[t] > 0) begin
            r.pos_x = 12'(lay_left[t] + int'($urandom_range(0, lay_wide[t] - 1)));
            r.pos_y = 12'(lay_top[t] + int'($urandom_range(0, lay_tall[t] - 1)));
         end
      end
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_payload);
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            if (w !== rsp_payload) begin
               $display("%0t: mismatch expected st=%b hit=%b lay=%0d off=%0d rect=%0d,%0d,%0d,%0d",
                        $time, w.status, w.hit, w.found_layer, w.buffer_offset,
                        w.rect_x0, w.rect_x1, w.rect_y0, w.rect_y1);
               $display("%0t:          actual st=%b hit=%b lay=%0d off=%0d rect=%0d,%0d,%0d,%0d",
                        $time, rsp_payload.status, rsp_payload.hit, rsp_payload.found_layer,
                        rsp_payload.buffer_offset, rsp_payload.rect_x0, rsp_payload.rect_x1,
                        rsp_payload.rect_y0, rsp_payload.rect_y1);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 21);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      req_type dir_req[$];
      rsp_type dir_rsp[$];
      bit      dir_typed[$];
      rsp_type z;
      int      ph, n;
      int      sw_set[5];
      int      sh_set[5];
      z = '0;
      lay_count = 0;
      dirty_x = 0; dirty_y = 0; dirty_w = 0; dirty_h = 0;
      scr_w = SCREEN_WIDTH_RESET;
      scr_h = SCREEN_HEIGHT_RESET;
      for (n = 0; n < MAX_LAYERS; n++) begin
         lay_left[n] = 0; lay_top[n] = 0; lay_wide[n] = 0; lay_tall[n] = 0;
      end

      dir_req = '{mk_req(CMD_FLUSH, 0, 0, 0, 0, 0), mk_req(CMD_MOVE, 0, 5, 5, 0, 0),
                  mk_req(CMD_REFRESH, 15, 0, 0, 0, 0), mk_req(CMD_RESOLVE, 0, 0, 0, 0, 0),
                  mk_req(3'd5, 15, -1, -1, 2047, 2047), mk_req(3'd6, 0, 0, 0, 0, 0),
                  mk_req(3'd7, 15, 2047, -2048, 2047, 0),
                  mk_req(CMD_CREATE, 0, -2048, -2048, 2047, 2047),
                  mk_req(CMD_CREATE, 0, 2047, 2047, 0, 0),
                  mk_req(CMD_CREATE, 0, 10, 20, 100, 50),
                  mk_req(CMD_RESOLVE, 0, 15, 25, 0, 0),
                  mk_req(CMD_RESOLVE, 0, -2048, -2048, 0, 0),
                  mk_req(CMD_RESOLVE, 0, 2047, 2047, 0, 0),
                  mk_req(CMD_MOVE, 3, 0, 0, 0, 0),
                  mk_req(CMD_REFRESH, 1, 0, 0, 0, 0), mk_req(CMD_FLUSH, 0, 0, 0, 0, 0),
                  mk_req(CMD_MOVE, 2, -5, -5, 0, 0), mk_req(CMD_FLUSH, 0, 0, 0, 0, 0),
                  mk_req(CMD_CREATE, 0, 50, 50, 0, 40), mk_req(CMD_REFRESH, 3, 0, 0, 0, 0),
                  mk_req(CMD_REFRESH, 0, 0, 0, 0, 0), mk_req(CMD_FLUSH, 0, 0, 0, 0, 0),
                  mk_req(CMD_RESOLVE, 0, 94, 44, 0, 0), mk_req(CMD_RESOLVE, 0, -1, -1, 0, 0)};
      dir_rsp = '{z, mk_rsp(1, 0, 0, 0), mk_rsp(1, 0, 0, 0), z, z, z, z,
                  mk_rsp(0, 0, 0, 0), mk_rsp(0, 0, 1, 0), mk_rsp(0, 0, 2, 0),
                  mk_rsp(0, 1, 2, 505), mk_rsp(0, 1, 0, 0), z, mk_rsp(1, 0, 0, 0),
                  z, z, z, z, mk_rsp(0, 0, 3, 0), z, z, z, z, z};
      dir_typed = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                    0, 0, 0, 0, 1, 0, 0, 0, 0, 0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (n = 0; n < dir_req.size(); n++) send_req(dir_req[n], dir_typed[n], dir_rsp[n]);
      drain_and_settle();

      sw_set = '{2047, 1, 0, 0, 320};
      sh_set = '{2047, 1, 0, 0, 200};
      sw_set[3] = $urandom_range(1, 2047);
      sh_set[3] = $urandom_range(1, 2047);
      for (ph = 0; ph < 5; ph++) begin
         write_csr(CSR_SCREEN_WIDTH, 11'(sw_set[ph]));
         write_csr(CSR_SCREEN_HEIGHT, 11'(sh_set[ph]));
         no_idle = (ph == 1);
         for (n = 0; n < 305; n++) send_req(random_req(), 1'b0, z);
         // sender holds off until every result is back
         drain_and_settle();
      end
      no_idle = 1'b0;

      if (errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
